@@ rtl/core/qvr_pkg.sv @@
// ---------------------------------------------------------------------------
// qvr_pkg: shared constants for the quaternion vector rotator
// Field widths, the fixed-point fraction length and the widths of the
// intermediate products and sums, all derived from those.
// ---------------------------------------------------------------------------
package qvr_pkg;

    localparam int IN_W      = 16;  // every input field
    localparam int OUT_W     = 18;  // every rotated component
    localparam int FRAC_BITS = 14;  // quaternion fraction bits, 8..30

    localparam int NUM_IN    = 7;
    localparam int S_DATA_W  = ((NUM_IN * IN_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;

    // q * (v,0): products of two input fields, sums of three of them
    localparam int PROD1_W   = 2 * IN_W;
    localparam int SUM1_W    = PROD1_W + 2;
    localparam int T_W       = SUM1_W - FRAC_BITS;

    // t * conj(q): products of t and q, sums of four of them
    localparam int PROD2_W   = T_W + IN_W;
    localparam int SUM2_W    = PROD2_W + 2;
    localparam int R_W       = (SUM2_W - FRAC_BITS > OUT_W) ? SUM2_W - FRAC_BITS : OUT_W + 1;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ rtl/core/quaternion_vector_rotate.sv @@
// ---------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a 3-vector by a Q2.14 quaternion
// Forms q * (v,0) * conj(q) with two Hamilton products, each floored by
// FRAC_BITS, and returns the vector part saturated to signed 18 bits.
// ---------------------------------------------------------------------------
// The block takes one item per cycle while the output does not stall and
// returns one result per item. The five register stages are: first products,
// first sums with flooring, second products, second sums with flooring,
// saturation into the output register. Backpressure travels back stage by
// stage, so empty stages keep filling while the output waits. The quaternion
// is not normalized: a non-unit q scales the vector by |q|^2. m_tuser is high
// when any of the three components was clipped.
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (16 bits each)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_x, out_y, out_z (18 bits each), zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // saturated
    output logic                m_tuser
);

    // stage enables: a stage loads when it is empty or its successor loads
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [IN_W-1:0] qx, qy, qz, qw, vx, vy, vz;

    logic signed [PROD1_W-1:0] p1_next [12];
    logic signed [PROD1_W-1:0] p1_reg  [12];
    logic signed [IN_W-1:0]    q1_reg  [4];

    logic signed [SUM1_W-1:0]  s1      [4];
    logic signed [T_W-1:0]     t_next  [4];
    logic signed [T_W-1:0]     t_reg   [4];
    logic signed [IN_W-1:0]    q2_reg  [4];

    logic signed [PROD2_W-1:0] p2_next [12];
    logic signed [PROD2_W-1:0] p2_reg  [12];

    logic signed [SUM2_W-1:0]  s2      [3];
    logic signed [R_W-1:0]     r_next  [3];
    logic signed [R_W-1:0]     r_reg   [3];

    logic signed [OUT_W-1:0]   o_next  [3];
    logic signed [OUT_W-1:0]   o_reg   [3];
    logic [2:0]                clip;
    logic                      sat_reg;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    assign qx = $signed(s_tdata[0*IN_W +: IN_W]);
    assign qy = $signed(s_tdata[1*IN_W +: IN_W]);
    assign qz = $signed(s_tdata[2*IN_W +: IN_W]);
    assign qw = $signed(s_tdata[3*IN_W +: IN_W]);
    assign vx = $signed(s_tdata[4*IN_W +: IN_W]);
    assign vy = $signed(s_tdata[5*IN_W +: IN_W]);
    assign vz = $signed(s_tdata[6*IN_W +: IN_W]);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: products of q * (v,0)
    always_comb begin
        p1_next[0]  = qw * vx;
        p1_next[1]  = qy * vz;
        p1_next[2]  = qz * vy;
        p1_next[3]  = qw * vy;
        p1_next[4]  = qz * vx;
        p1_next[5]  = qx * vz;
        p1_next[6]  = qw * vz;
        p1_next[7]  = qx * vy;
        p1_next[8]  = qy * vx;
        p1_next[9]  = qx * vx;
        p1_next[10] = qy * vy;
        p1_next[11] = qz * vz;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_reg    <= p1_next;
            q1_reg[0] <= qx;
            q1_reg[1] <= qy;
            q1_reg[2] <= qz;
            q1_reg[3] <= qw;
        end
    end

    // stage 2: sums, floored by the fraction bits (arithmetic shift)
    always_comb begin
        s1[0] = SUM1_W'(p1_reg[0]) + SUM1_W'(p1_reg[1]) - SUM1_W'(p1_reg[2]);
        s1[1] = SUM1_W'(p1_reg[3]) + SUM1_W'(p1_reg[4]) - SUM1_W'(p1_reg[5]);
        s1[2] = SUM1_W'(p1_reg[6]) + SUM1_W'(p1_reg[7]) - SUM1_W'(p1_reg[8]);
        s1[3] = -SUM1_W'(p1_reg[9]) - SUM1_W'(p1_reg[10]) - SUM1_W'(p1_reg[11]);
        for (int i = 0; i < 4; i++) begin
            t_next[i] = T_W'(s1[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            t_reg  <= t_next;
            q2_reg <= q1_reg;
        end
    end

    // stage 3: products of t * conj(q); t_reg is x, y, z, w
    always_comb begin
        p2_next[0]  = t_reg[0] * q2_reg[3];
        p2_next[1]  = t_reg[3] * q2_reg[0];
        p2_next[2]  = t_reg[1] * q2_reg[2];
        p2_next[3]  = t_reg[2] * q2_reg[1];
        p2_next[4]  = t_reg[1] * q2_reg[3];
        p2_next[5]  = t_reg[3] * q2_reg[1];
        p2_next[6]  = t_reg[2] * q2_reg[0];
        p2_next[7]  = t_reg[0] * q2_reg[2];
        p2_next[8]  = t_reg[2] * q2_reg[3];
        p2_next[9]  = t_reg[3] * q2_reg[2];
        p2_next[10] = t_reg[0] * q2_reg[1];
        p2_next[11] = t_reg[1] * q2_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            p2_reg <= p2_next;
        end
    end

    // stage 4: vector part sums, floored
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2[i] = SUM2_W'(p2_reg[4*i]) - SUM2_W'(p2_reg[4*i+1])
                  - SUM2_W'(p2_reg[4*i+2]) + SUM2_W'(p2_reg[4*i+3]);
            r_next[i] = R_W'(s2[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            r_reg <= r_next;
        end
    end

    // stage 5: clip to the output range when the upper bits are not all sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            clip[i] = (|r_reg[i][R_W-1:OUT_W-1]) && !(&r_reg[i][R_W-1:OUT_W-1]);
            if (clip[i]) begin
                o_next[i] = r_reg[i][R_W-1] ? OUT_MIN : OUT_MAX;
            end else begin
                o_next[i] = r_reg[i][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            o_reg   <= o_next;
            sat_reg <= |clip;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tuser  = sat_reg;
    assign m_tdata  = {{(M_DATA_W - 3*OUT_W){1'b0}}, o_reg[2], o_reg[1], o_reg[0]};

    // a full pipeline held by the output is the only reason to refuse input
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !m_tready))
        else $error("input refused while the pipeline has room");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item did not enter the first stage");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (o_reg[0] == OUT_MAX || o_reg[0] == OUT_MIN
            || o_reg[1] == OUT_MAX || o_reg[1] == OUT_MIN
            || o_reg[2] == OUT_MAX || o_reg[2] == OUT_MIN))
        else $error("saturation flagged with no component at a bound");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!v1_reg && !v2_reg && !v3_reg && !v4_reg && !m_tvalid))
        else $error("pipeline not empty after reset");

endmodule
